@@ rtl/btc_pkg.sv @@
// shared types and constants for the barometric compensation unit
// used by btc_front, btc_queue, btc_back and the top level; no dependencies
`default_nettype none
package btc_pkg;

  localparam logic [19:0] OFF_CODE     = 20'h80000;
  localparam logic [63:0] TFINE_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_SCALE  = 64'd3125;
  localparam logic [63:0] PRESS_BASE   = 64'd1048576;
  localparam logic [63:0] MASK24       = 64'hFF_FFFF;

  localparam logic [1:0] REG_CAL_TEMP    = 2'd0;
  localparam logic [1:0] REG_CAL_PRESS_A = 2'd1;
  localparam logic [1:0] REG_CAL_PRESS_B = 2'd2;
  localparam logic [1:0] REG_CAL_PRESS_C = 2'd3;

  localparam int TFINE_W = 26;

  // one classified item between front and back
  typedef struct packed {
    logic [19:0]        raw_press;
    logic [TFINE_W-1:0] tfine;
    logic [23:0]        temp_centi;
    logic               temp_valid;
    logic               press_valid;
  } btc_item_t;

  function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned s);
    asr64 = 64'($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

@@ rtl/btc_front.sv @@
// front end: accepts raw readings, computes fine temperature and centidegrees
// depends on btc_pkg
`default_nettype none
module btc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [19:0]       raw_press,
  input  wire logic [19:0]       raw_temp,
  input  wire logic [47:0]       cal_temp,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output btc_pkg::btc_item_t     push_item
);
  import btc_pkg::*;

  logic               en;
  logic               s1_valid;
  logic               s2_valid;
  logic signed [17:0] d1;
  logic signed [17:0] d2;
  logic signed [33:0] prod1;
  logic [32:0]        sq;
  logic [19:0]        s1_press;
  logic               s1_tv;
  logic               s1_pv;
  logic signed [22:0] v1;
  logic signed [37:0] v2p;
  logic [19:0]        s2_press;
  logic               s2_tv;
  logic               s2_pv;
  logic signed [23:0] v2;
  logic signed [TFINE_W-1:0] tfine;
  logic signed [29:0] t5;
  logic signed [21:0] tc;
  logic signed [32:0] sq_full;

  assign en       = !s2_valid || push_ready;
  assign in_ready = en;

  assign d1      = $signed({1'b0, raw_temp[19:3]}) - $signed({1'b0, cal_temp[15:0], 1'b0});
  assign d2      = $signed({2'b0, raw_temp[19:4]}) - $signed({2'b0, cal_temp[15:0]});
  assign sq_full = d2 * d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1    <= 34'(d1 * $signed(cal_temp[31:16]));
      sq       <= sq_full;
      s1_press <= raw_press;
      s1_tv    <= (raw_temp != OFF_CODE);
      s1_pv    <= (raw_press != OFF_CODE);
      v1       <= 23'(prod1 >>> 11);
      v2p      <= 38'($signed({1'b0, sq[32:12]}) * $signed(cal_temp[47:32]));
      s2_press <= s1_press;
      s2_tv    <= s1_tv;
      s2_pv    <= s1_pv;
    end
  end

  assign v2    = 24'(v2p >>> 14);
  assign tfine = TFINE_W'(v1) + TFINE_W'(v2);
  assign t5    = (30'(tfine) <<< 2) + 30'(tfine) + 30'sd128;
  assign tc    = 22'(t5 >>> 8);

  assign push_valid             = s2_valid;
  assign push_item.raw_press    = s2_press;
  assign push_item.tfine        = tfine;
  assign push_item.temp_centi   = s2_tv ? 24'(tc) : 24'd0;
  assign push_item.temp_valid   = s2_tv;
  assign push_item.press_valid  = s2_pv;

endmodule
`default_nettype wire

@@ rtl/btc_queue.sv @@
// two-entry queue decoupling front and back
// depends on btc_pkg
`default_nettype none
module btc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire btc_pkg::btc_item_t push_item,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output btc_pkg::btc_item_t pop_item
);
  import btc_pkg::*;

  btc_item_t  entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= push_item;
  end

endmodule
`default_nettype wire

@@ rtl/btc_back.sv @@
// back end: pressure compensation sequencer with shared 64x16 multiplier and divider
// depends on btc_pkg
`default_nettype none
module btc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pop_valid,
  output logic               pop_ready,
  input  wire btc_pkg::btc_item_t pop_item,
  input  wire logic [63:0]   cal_press_a,
  input  wire logic [63:0]   cal_press_b,
  input  wire logic [15:0]   cal_press_c,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [23:0]        temp_centi,
  output logic [23:0]        pressure_pa,
  output logic               temp_valid,
  output logic               press_valid,
  output logic               divisor_zero
);
  import btc_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL    = 4'd1;
  localparam logic [3:0] ST_AA     = 4'd2;
  localparam logic [3:0] ST_B1     = 4'd3;
  localparam logic [3:0] ST_B2     = 4'd4;
  localparam logic [3:0] ST_A2     = 4'd5;
  localparam logic [3:0] ST_A3     = 4'd6;
  localparam logic [3:0] ST_NUM    = 4'd7;
  localparam logic [3:0] ST_DIV    = 4'd8;
  localparam logic [3:0] ST_DIVEND = 4'd9;
  localparam logic [3:0] ST_V1A    = 4'd10;
  localparam logic [3:0] ST_V1B    = 4'd11;
  localparam logic [3:0] ST_V2     = 4'd12;
  localparam logic [3:0] ST_DONE   = 4'd13;

  logic [3:0]  state;
  logic [3:0]  ret;
  logic [63:0] mul_x;
  logic [63:0] mul_y;
  logic        mul_full;
  logic [1:0]  mul_k;
  logic [63:0] acc;
  logic [16:0] chunk;
  logic [63:0] term;
  logic [63:0] var_a;
  logic [63:0] var_aa;
  logic [63:0] var_b;
  logic [63:0] var_p;
  logic [63:0] var_v1;
  logic [63:0] den;
  logic [63:0] quo;
  logic [63:0] dmag;
  logic [64:0] rem;
  logic        qneg;
  logic [5:0]  div_cnt;
  logic [19:0] r_press_raw;
  logic [23:0] r_temp;
  logic        r_tv;
  logic        r_pv;
  logic        r_dz;
  logic [23:0] r_press;
  logic [64:0] rem_sh;
  logic [63:0] a2_new;
  logic [63:0] pf;
  logic [63:0] den_new;
  logic [63:0] num_x;
  logic [63:0] p_signed;

  assign pop_ready = (state == ST_IDLE);

  // one 64x16 partial product per cycle; a short operand takes one pass
  assign chunk = mul_full ? {1'b0, mul_y[{mul_k, 4'b0} +: 16]} : mul_y[16:0];
  assign term  = 64'(mul_x * chunk[15:0]) - (chunk[16] ? (mul_x << 16) : 64'd0);

  assign rem_sh   = {rem[63:0], quo[63]};
  assign a2_new   = asr64(var_aa + sx16(cal_press_a[47:32]), 8) + (acc << 12);
  assign den_new  = asr64(acc, 33);
  assign num_x    = (((PRESS_BASE - {44'd0, r_press_raw}) << 31) - var_b);
  assign p_signed = qneg ? (64'd0 - quo) : quo;
  assign pf       = asr64(var_p + var_v1 + asr64(acc, 19), 8)
                    + (sx16(cal_press_b[47:32]) << 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            r_press_raw <= pop_item.raw_press;
            r_temp      <= pop_item.temp_centi;
            r_tv        <= pop_item.temp_valid;
            r_pv        <= pop_item.press_valid;
            r_dz        <= 1'b0;
            r_press     <= 24'd0;
            var_a       <= {{(64-TFINE_W){pop_item.tfine[TFINE_W-1]}}, pop_item.tfine}
                           - TFINE_OFFSET;
            mul_x       <= {{(64-TFINE_W){pop_item.tfine[TFINE_W-1]}}, pop_item.tfine}
                           - TFINE_OFFSET;
            mul_y       <= {{(64-TFINE_W){pop_item.tfine[TFINE_W-1]}}, pop_item.tfine}
                           - TFINE_OFFSET;
            mul_full    <= 1'b1;
            mul_k       <= 2'd0;
            acc         <= 64'd0;
            ret         <= ST_AA;
            state       <= pop_item.press_valid ? ST_MUL : ST_DONE;
          end
        end
        ST_MUL: begin
          acc <= acc + (term << {mul_k, 4'b0});
          if (!mul_full || mul_k == 2'd3) begin
            mul_k <= 2'd0;
            state <= ret;
          end else begin
            mul_k <= mul_k + 2'd1;
          end
        end
        ST_AA: begin
          var_aa   <= acc;
          mul_x    <= acc;
          mul_y    <= sx16(cal_press_b[31:16]);
          mul_full <= 1'b0;
          acc      <= 64'd0;
          ret      <= ST_B1;
          state    <= ST_MUL;
        end
        ST_B1: begin
          var_b    <= acc;
          mul_x    <= var_a;
          mul_y    <= sx16(cal_press_b[15:0]);
          mul_full <= 1'b0;
          acc      <= 64'd0;
          ret      <= ST_B2;
          state    <= ST_MUL;
        end
        ST_B2: begin
          var_b    <= var_b + (acc << 17) + (sx16(cal_press_a[63:48]) << 35);
          mul_x    <= var_a;
          mul_y    <= sx16(cal_press_a[31:16]);
          mul_full <= 1'b0;
          acc      <= 64'd0;
          ret      <= ST_A2;
          state    <= ST_MUL;
        end
        ST_A2: begin
          mul_x    <= (64'd1 << 47) + a2_new;
          mul_y    <= {48'd0, cal_press_a[15:0]};
          mul_full <= 1'b0;
          acc      <= 64'd0;
          ret      <= ST_A3;
          state    <= ST_MUL;
        end
        ST_A3: begin
          den <= den_new;
          if (den_new == 64'd0) begin
            r_dz  <= 1'b1;
            state <= ST_DONE;
          end else begin
            mul_x    <= num_x;
            mul_y    <= PRESS_SCALE;
            mul_full <= 1'b0;
            acc      <= 64'd0;
            ret      <= ST_NUM;
            state    <= ST_MUL;
          end
        end
        ST_NUM: begin
          quo     <= acc[63] ? (64'd0 - acc) : acc;
          dmag    <= den[63] ? (64'd0 - den) : den;
          qneg    <= acc[63] ^ den[63];
          rem     <= 65'd0;
          div_cnt <= 6'd0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          // restoring division, one quotient bit a cycle
          if (rem_sh >= {1'b0, dmag}) begin
            rem <= rem_sh - {1'b0, dmag};
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[62:0], 1'b0};
          end
          div_cnt <= div_cnt + 6'd1;
          if (div_cnt == 6'd63) state <= ST_DIVEND;
        end
        ST_DIVEND: begin
          var_p    <= p_signed;
          mul_x    <= asr64(p_signed, 13);
          mul_y    <= sx16(cal_press_c);
          mul_full <= 1'b0;
          acc      <= 64'd0;
          ret      <= ST_V1A;
          state    <= ST_MUL;
        end
        ST_V1A: begin
          mul_x    <= acc;
          mul_y    <= asr64(var_p, 13);
          mul_full <= 1'b1;
          mul_k    <= 2'd0;
          acc      <= 64'd0;
          ret      <= ST_V1B;
          state    <= ST_MUL;
        end
        ST_V1B: begin
          var_v1   <= asr64(acc, 25);
          mul_x    <= var_p;
          mul_y    <= sx16(cal_press_b[63:48]);
          mul_full <= 1'b0;
          acc      <= 64'd0;
          ret      <= ST_V2;
          state    <= ST_MUL;
        end
        ST_V2: begin
          if (pf[63])                    r_press <= 24'd0;
          else if ((pf >> 8) > MASK24)   r_press <= 24'hFF_FFFF;
          else                           r_press <= pf[31:8];
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            temp_centi   <= r_temp;
            pressure_pa  <= r_press;
            temp_valid   <= r_tv;
            press_valid  <= r_pv;
            divisor_zero <= r_dz;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/baro_temp_compensation_unit.sv @@
// top level of the barometric compensation unit: calibration registers and wiring
// depends on btc_pkg, btc_front, btc_queue and btc_back
`default_nettype none
// takes raw 20-bit pressure and temperature pairs and returns temperature in
// hundredths of a degree and pressure in whole pascals, one result per request.
// the front pipeline works out the temperature and takes a new request every
// cycle while the two-entry queue has room. the back end computes pressure with
// one shared 64x16 multiplier, fed a full 64-bit operand in 16-bit chunks, and a
// radix-2 divider; it takes one request at a time and accepts the next only when
// idle again. a request with pressure off skips the pressure path, and a zero
// divisor ends it early. calibration is written through cfg_we/cfg_index/cfg_data
// by the user only while the unit is idle; the block itself does not enforce it.
module baro_temp_compensation_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [19:0] raw_press,
  input  wire logic [19:0] raw_temp,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [23:0] temp_centi,
  output logic [23:0]      pressure_pa,
  output logic             temp_valid,
  output logic             press_valid,
  output logic             divisor_zero,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import btc_pkg::*;

  logic [47:0] cal_temp;
  logic [63:0] cal_press_a;
  logic [63:0] cal_press_b;
  logic [15:0] cal_press_c;
  logic        push_valid;
  logic        push_ready;
  btc_item_t   push_item;
  logic        pop_valid;
  logic        pop_ready;
  btc_item_t   pop_item;
  logic [23:0] temp_bits;

  // calibration registers, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp    <= 48'd0;
      cal_press_a <= 64'd0;
      cal_press_b <= 64'd0;
      cal_press_c <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_TEMP:    cal_temp    <= cfg_data[47:0];
        REG_CAL_PRESS_A: cal_press_a <= cfg_data;
        REG_CAL_PRESS_B: cal_press_b <= cfg_data;
        REG_CAL_PRESS_C: cal_press_c <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // front: temperature pipeline
  btc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .raw_press  (raw_press),
    .raw_temp   (raw_temp),
    .cal_temp   (cal_temp),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // queue between the two halves
  btc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // back: pressure sequencer and output register
  btc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .cal_press_a  (cal_press_a),
    .cal_press_b  (cal_press_b),
    .cal_press_c  (cal_press_c),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .temp_centi   (temp_bits),
    .pressure_pa  (pressure_pa),
    .temp_valid   (temp_valid),
    .press_valid  (press_valid),
    .divisor_zero (divisor_zero)
  );

  assign temp_centi = $signed(temp_bits);

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// self-checking testbench for baro_temp_compensation_unit
// depends on btc_pkg and the unit's rtl; directed table then random requests
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import btc_pkg::*;

  // one result as seen on the output channel
  typedef struct packed {
    logic [23:0] temp_centi;
    logic [23:0] pressure_pa;
    logic        temp_valid;
    logic        press_valid;
    logic        divisor_zero;
  } comp_result_t;

  // one row of the directed table; has_exp marks a typed-in expected result
  typedef struct {
    logic [19:0]  rp;
    logic [19:0]  rt;
    bit           has_exp;
    comp_result_t exp_res;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [19:0] raw_press;
  logic [19:0] raw_temp;
  logic        out_valid;
  logic        out_ready;
  logic signed [23:0] temp_centi;
  logic [23:0] pressure_pa;
  logic        temp_valid;
  logic        press_valid;
  logic        divisor_zero;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  baro_temp_compensation_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .raw_press(raw_press), .raw_temp(raw_temp),
    .out_valid(out_valid), .out_ready(out_ready),
    .temp_centi(temp_centi), .pressure_pa(pressure_pa),
    .temp_valid(temp_valid), .press_valid(press_valid),
    .divisor_zero(divisor_zero),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // local copy of the calibration registers
  logic [47:0] cal_t;
  logic [63:0] cal_pa;
  logic [63:0] cal_pb;
  logic [15:0] cal_pc;

  comp_result_t pending_q[$];
  int unsigned  fail_count;
  longint unsigned cycle_count;
  bit           stall_long;

  localparam longint unsigned CYCLE_LIMIT = 64'd4_000_000;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // signed truncating division on 64-bit wrapped operands
  function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q  = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic logic [63:0] sar(input logic [63:0] v, input int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [63:0] sext(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // compensation predictor: temperature then 64-bit pressure path
  function automatic comp_result_t compensate(input logic [19:0] rp, input logic [19:0] rt);
    comp_result_t r;
    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] d1, d2, v1, v2, tfine, tc, a, b, p;
    longint ts;
    t1 = {48'd0, cal_t[15:0]};
    t2 = sext(cal_t[31:16]);
    t3 = sext(cal_t[47:32]);
    p1 = {48'd0, cal_pa[15:0]};
    p2 = sext(cal_pa[31:16]);
    p3 = sext(cal_pa[47:32]);
    p4 = sext(cal_pa[63:48]);
    p5 = sext(cal_pb[15:0]);
    p6 = sext(cal_pb[31:16]);
    p7 = sext(cal_pb[47:32]);
    p8 = sext(cal_pb[63:48]);
    p9 = sext(cal_pc);
    r = '0;
    r.temp_valid  = (rt != OFF_CODE);
    r.press_valid = (rp != OFF_CODE);
    d1 = {44'd0, rt >> 3} - (t1 << 1);
    v1 = sar(d1 * t2, 11);
    d2 = {44'd0, rt >> 4} - t1;
    v2 = sar(sar(d2 * d2, 12) * t3, 14);
    tfine = v1 + v2;
    tc = sar(tfine * 64'd5 + 64'd128, 8);
    ts = $signed(tc);
    if (ts > 8388607) ts = 8388607;
    if (ts < -8388608) ts = -8388608;
    if (r.temp_valid) r.temp_centi = ts[23:0];
    if (r.press_valid) begin
      a = tfine - 64'd128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 << 35);
      a = sar(a * a + p3, 8) + ((a * p2) << 12);
      a = ((64'd1 << 47) + a) * p1;
      a = sar(a, 33);
      if (a == 0) begin
        r.divisor_zero = 1'b1;
      end else begin
        p = 64'd1048576 - {44'd0, rp};
        p = div_trunc(((p << 31) - b) * 64'd3125, a);
        v1 = sar(p9 * sar(p, 13) * sar(p, 13), 25);
        v2 = sar(p8 * p, 19);
        p = sar(p + v1 + v2, 8) + (p7 << 4);
        if (!p[63]) begin
          p = p >> 8;
          r.pressure_pa = (p > 64'hFF_FFFF) ? 24'hFF_FFFF : p[23:0];
        end
      end
    end
    return r;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int w;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      if (stall_long) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        stall_long = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  // result checker: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    comp_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result temp=%0d press=%0d", temp_centi, pressure_pa);
        fail_count++;
      end else begin
        e = pending_q.pop_front();
        if (temp_centi !== e.temp_centi) begin
          $error("temp_centi exp %0d got %0d", $signed(e.temp_centi), temp_centi);
          fail_count++;
        end
        if (pressure_pa !== e.pressure_pa) begin
          $error("pressure_pa exp %0d got %0d", e.pressure_pa, pressure_pa);
          fail_count++;
        end
        if (temp_valid !== e.temp_valid) begin
          $error("temp_valid exp %0b got %0b", e.temp_valid, temp_valid);
          fail_count++;
        end
        if (press_valid !== e.press_valid) begin
          $error("press_valid exp %0b got %0b", e.press_valid, press_valid);
          fail_count++;
        end
        if (divisor_zero !== e.divisor_zero) begin
          $error("divisor_zero exp %0b got %0b", e.divisor_zero, divisor_zero);
          fail_count++;
        end
      end
    end
  end

  // register write, only while idle; cfg_we is cleared again after each write
  task automatic write_cal(input logic [1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_CAL_TEMP:    cal_t  = val[47:0];
      REG_CAL_PRESS_A: cal_pa = val;
      REG_CAL_PRESS_B: cal_pb = val;
      default:         cal_pc = val[15:0];
    endcase
    @(posedge clk);
  endtask

  // send one request; the expectation is queued as it is accepted
  task automatic send_request(input logic [19:0] rp, input logic [19:0] rt,
                              input bit has_exp, input comp_result_t exp_res,
                              input bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 8) : 0;
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_valid  <= 1'b1;
    raw_press <= rp;
    raw_temp  <= rt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_q.push_back(has_exp ? exp_res : compensate(rp, rt));
  endtask

  // wait until every result is back, then a short settle before register writes
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // typical sensor calibration words
  task automatic load_typical;
    write_cal(REG_CAL_TEMP, 64'({16'(-16'sd1000), 16'sd26435, 16'd27504}));
    write_cal(REG_CAL_PRESS_A, {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477});
    write_cal(REG_CAL_PRESS_B, {-16'sd7, 16'sd15500, -16'sd7, 16'sd140});
    write_cal(REG_CAL_PRESS_C, 64'(16'sd6000));
  endtask

  function automatic logic [19:0] rand_code(input bit near_typ);
    if (near_typ) return 20'($urandom_range(350000, 700000));
    return 20'($urandom_range(0, 20'hFFFFF));
  endfunction

  stim_row_t dir_tab[$];
  comp_result_t zr;
  logic [19:0] rp, rt;
  int k;

  initial begin
    in_valid = 1'b0; raw_press = '0; raw_temp = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    rst = 1'b1; fail_count = 0; cycle_count = 0;
    stall_long = 1'b0;
    cal_t = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset all calibration is zero: divisor is zero unless pressure is off
    zr = '0; zr.temp_valid = 1; zr.press_valid = 1; zr.divisor_zero = 1;
    dir_tab.push_back('{20'h00000, 20'h00000, 1'b1, zr});
    dir_tab.push_back('{20'hFFFFF, 20'hFFFFF, 1'b1, zr});
    zr = '0; zr.temp_valid = 1;
    dir_tab.push_back('{OFF_CODE, 20'h12345, 1'b1, zr});
    zr = '0; zr.press_valid = 1; zr.divisor_zero = 1;
    dir_tab.push_back('{20'h54321, OFF_CODE, 1'b1, zr});
    zr = '0;
    dir_tab.push_back('{OFF_CODE, OFF_CODE, 1'b1, zr});
    foreach (dir_tab[i])
      send_request(dir_tab[i].rp, dir_tab[i].rt, 1'b1, dir_tab[i].exp_res, 1'b0);
    drain();

    // typical calibration, extremes and off codes through the predictor
    load_typical();
    dir_tab = {};
    dir_tab.push_back('{20'd415148, 20'd519888, 1'b0, zr});
    dir_tab.push_back('{20'h00000, 20'h00000, 1'b0, zr});
    dir_tab.push_back('{20'hFFFFF, 20'hFFFFF, 1'b0, zr});
    dir_tab.push_back('{20'h00000, 20'hFFFFF, 1'b0, zr});
    dir_tab.push_back('{20'hFFFFF, 20'h00000, 1'b0, zr});
    dir_tab.push_back('{OFF_CODE, 20'd519888, 1'b0, zr});
    dir_tab.push_back('{20'd415148, OFF_CODE, 1'b0, zr});
    dir_tab.push_back('{20'h7FFFF, 20'h80001, 1'b0, zr});
    foreach (dir_tab[i]) send_request(dir_tab[i].rp, dir_tab[i].rt, 1'b0, zr, 1'b1);
    drain();

    // register extremes: mostly all-ones, sign-bit and max-positive patterns
    write_cal(REG_CAL_TEMP, 64'hFFFF_FFFF_FFFF);
    write_cal(REG_CAL_PRESS_A, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(REG_CAL_PRESS_B, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cal(REG_CAL_PRESS_C, 64'h7FFF);
    send_request(20'h00000, 20'hFFFFF, 1'b0, zr, 1'b0);
    send_request(20'hFFFFF, 20'h00000, 1'b0, zr, 1'b0);
    drain();
    write_cal(REG_CAL_TEMP, 64'h8000_8000_0000);
    write_cal(REG_CAL_PRESS_A, 64'h8000_8000_8000_FFFF);
    write_cal(REG_CAL_PRESS_B, 64'h8000_7FFF_8000_7FFF);
    write_cal(REG_CAL_PRESS_C, 64'h8000);
    send_request(20'h00000, 20'hFFFFF, 1'b0, zr, 1'b0);
    send_request(20'hFFFFF, 20'h00000, 1'b0, zr, 1'b0);
    drain();

    // random phases; half with realistic calibration, half with random words
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0) begin
        load_typical();
        write_cal(REG_CAL_TEMP, 64'({16'($urandom), 16'($urandom_range(20000, 30000)),
                                     16'($urandom_range(26000, 30000))}));
      end else begin
        write_cal(REG_CAL_TEMP, {$urandom, $urandom});
        write_cal(REG_CAL_PRESS_A, {$urandom, $urandom});
        write_cal(REG_CAL_PRESS_B, {$urandom, $urandom});
        write_cal(REG_CAL_PRESS_C, 64'($urandom));
      end
      // long hold-off on the result side while requests keep coming
      if (ph == 1) stall_long = 1'b1;
      for (k = 0; k < 250; k++) begin
        rp = rand_code(ph % 2 == 0 && $urandom_range(0, 3) != 0);
        rt = rand_code(ph % 2 == 0 && $urandom_range(0, 3) != 0);
        if ($urandom_range(0, 19) == 0) rp = OFF_CODE;
        if ($urandom_range(0, 19) == 0) rt = OFF_CODE;
        // one pause until everything is back
        if (k == 100 && ph == 2) begin
          in_valid <= 1'b0;
          while (pending_q.size() != 0) @(posedge clk);
        end
        send_request(rp, rt, 1'b0, zr, $urandom_range(0, 4) != 0);
      end
      drain();
    end

    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
